// File: src/word_mix_hash_stream_core_defines.svh
// assertion macros for the word mix hash stream core
// used by files that carry concurrent checks; no other dependencies
`ifndef WORD_MIX_HASH_STREAM_CORE_DEFINES_SVH
`define WORD_MIX_HASH_STREAM_CORE_DEFINES_SVH

// same-cycle implication, checked only out of reset
`define WMH_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("wmh check failed: same cycle");

// next-cycle implication, checked only out of reset
`define WMH_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("wmh check failed: next cycle");

`endif

// File: src/wmh_pkg.sv
// shared types, constants and helpers for the word mix hash stream core
// no dependencies
package wmh_pkg;

    localparam int WordW  = 64;
    localparam int HalfW  = 32;
    localparam int CountW = 4;
    localparam int LenW   = 8;
    localparam int BytesPerWord = 8;

    localparam logic [WordW-1:0] HashInit = 64'd2166136261;
    localparam logic [WordW-1:0] MixFull  = 64'hbf58476d1ce4e5b9;
    localparam logic [WordW-1:0] MixTail  = 64'hd6e8feb86659fd93;
    localparam logic [LenW-1:0]  LenInit  = 8'h00;

    // request handed from the word front end to the mixer and state update
    typedef struct packed {
        logic [WordW-1:0] operand;   // hash xor word or tail
        logic             use_tail;  // select tail constant
        logic             do_mix;    // beat carries bytes
        logic             fin;       // beat closes the message
        logic [LenW-1:0]  len_next;  // length after this beat
    } mix_req_t;

    function automatic logic [HalfW-1:0] fold_hash(input logic [WordW-1:0] h);
        fold_hash = h[HalfW-1:0] ^ h[WordW-1:HalfW];
    endfunction

endpackage

// File: src/wmh_front.sv
// word front end: count saturation, byte masking, tail build and length update
// depends on wmh_pkg
module wmh_front (
    input  logic [wmh_pkg::WordW-1:0]  data_word,
    input  logic [wmh_pkg::CountW-1:0] byte_count,
    input  logic                       last,
    input  logic [wmh_pkg::WordW-1:0]  hash_cur,
    input  logic [wmh_pkg::LenW-1:0]   len_cur,
    output wmh_pkg::mix_req_t          req
);

    logic                       full_word;
    logic [wmh_pkg::CountW-1:0] count_sat;
    logic                       short_word;
    logic [wmh_pkg::WordW-9:0]  masked;
    logic [wmh_pkg::LenW-1:0]   len_add;
    logic [wmh_pkg::WordW-1:0]  tail;

    assign full_word  = byte_count[wmh_pkg::CountW-1];
    assign count_sat  = full_word ? wmh_pkg::CountW'(wmh_pkg::BytesPerWord) : byte_count;
    assign short_word = !full_word && (byte_count != '0);

    // keep byte b only while b is below the count; a tail never reaches the top byte
    always_comb begin
        for (int b = 0; b < wmh_pkg::BytesPerWord - 1; b++) begin
            masked[b*8 +: 8] = (wmh_pkg::CountW'(b) < count_sat) ? data_word[b*8 +: 8]
                                                                 : 8'h00;
        end
    end

    assign len_add = len_cur + wmh_pkg::LenW'(count_sat);
    assign tail    = {masked, len_add};

    always_comb begin
        req.operand  = hash_cur ^ (full_word ? data_word : tail);
        req.use_tail = short_word;
        req.do_mix   = full_word || short_word;
        req.fin      = last || short_word;
        req.len_next = len_add;
    end

endmodule

// File: src/wmh_mix.sv
// 64-bit modular multiply by one of two mix constants, built from 32-bit partial products
// depends on wmh_pkg
module wmh_mix (
    input  logic [wmh_pkg::WordW-1:0] operand,
    input  logic                      use_tail,
    output logic [wmh_pkg::WordW-1:0] product
);

    logic [wmh_pkg::WordW-1:0] k;
    logic [wmh_pkg::HalfW-1:0] a_lo, a_hi, k_lo, k_hi;
    logic [wmh_pkg::WordW-1:0] p_ll;
    logic [wmh_pkg::HalfW-1:0] p_lh, p_hl;

    assign k    = use_tail ? wmh_pkg::MixTail : wmh_pkg::MixFull;
    assign a_lo = operand[wmh_pkg::HalfW-1:0];
    assign a_hi = operand[wmh_pkg::WordW-1:wmh_pkg::HalfW];
    assign k_lo = k[wmh_pkg::HalfW-1:0];
    assign k_hi = k[wmh_pkg::WordW-1:wmh_pkg::HalfW];

    // high-by-high term falls outside 64 bits; cross terms only need their low halves
    assign p_ll = wmh_pkg::WordW'(a_lo) * wmh_pkg::WordW'(k_lo);
    assign p_lh = a_lo * k_hi;
    assign p_hl = a_hi * k_lo;

    assign product = p_ll + {p_lh + p_hl, {wmh_pkg::HalfW{1'b0}}};

endmodule

// File: src/word_mix_hash_stream_core.sv
// top level of the word mix hash stream core: handshakes, hash state, result register
// depends on wmh_pkg, wmh_front, wmh_mix and word_mix_hash_stream_core_defines.svh
`include "word_mix_hash_stream_core_defines.svh"

// streaming hash of a byte message sent as little-endian 64-bit words, one word per
// beat. each beat carries the word, a byte count (9 to 15 behave as 8) and tlast.
// a full word is folded in with one constant, a short word of 1 to 7 bytes forms a
// tail (length mod 256 in the low byte, bytes above) folded in with a second constant
// and always closes the message. a closing beat, or an empty beat with tlast, puts the
// 32-bit fold of the hash on the result channel and restarts the hash. an empty beat
// without tlast does nothing. the core takes one beat per clock cycle while the input
// is not stalled; a closing beat writes its fold into the result register. the rate is
// set by the combinational feedback loop (xor plus 64-bit constant multiply) on hash_reg.
// the result register holds a finished hash while input beats keep flowing, and the
// input stalls only when that register is full and the result side is not taking it.
module word_mix_hash_stream_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,    // [63:0] data_word, [67:64] byte_count, [71:68] zero
    input  logic        s_tlast,    // last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata     // [31:0] hash_value
);

    logic [wmh_pkg::WordW-1:0] hash_reg, hash_next;
    logic [wmh_pkg::LenW-1:0]  len_reg, len_next;
    logic                      out_valid_reg, out_valid_next;
    logic [wmh_pkg::HalfW-1:0] out_data_reg, out_data_next;

    wmh_pkg::mix_req_t         req;
    logic [wmh_pkg::WordW-1:0] product;
    logic [wmh_pkg::WordW-1:0] hash_after;
    logic                      s_fire;
    logic                      m_fire;

    // input is free whenever the result register is empty or being drained
    assign s_tready = !out_valid_reg || m_tready;
    assign s_fire   = s_tvalid && s_tready;
    assign m_fire   = out_valid_reg && m_tready;

    wmh_front u_front (
        .data_word  (s_tdata[wmh_pkg::WordW-1:0]),
        .byte_count (s_tdata[wmh_pkg::WordW +: wmh_pkg::CountW]),
        .last       (s_tlast),
        .hash_cur   (hash_reg),
        .len_cur    (len_reg),
        .req        (req)
    );

    wmh_mix u_mix (
        .operand  (req.operand),
        .use_tail (req.use_tail),
        .product  (product)
    );

    // empty beat leaves the hash as it is
    assign hash_after = req.do_mix ? product : hash_reg;

    always_comb begin
        hash_next      = hash_reg;
        len_next       = len_reg;
        out_valid_next = out_valid_reg && !m_fire;
        out_data_next  = out_data_reg;
        if (s_fire) begin
            if (req.fin) begin
                // message closed: emit fold and restart
                hash_next      = wmh_pkg::HashInit;
                len_next       = wmh_pkg::LenInit;
                out_valid_next = 1'b1;
                out_data_next  = wmh_pkg::fold_hash(hash_after);
            end else begin
                hash_next = hash_after;
                len_next  = req.do_mix ? req.len_next : len_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hash_reg      <= wmh_pkg::HashInit;
            len_reg       <= wmh_pkg::LenInit;
            out_valid_reg <= 1'b0;
        end else begin
            hash_reg      <= hash_next;
            len_reg       <= len_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload, no reset needed
    always_ff @(posedge aclk) begin
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // a closing beat leaves the state at its initial value
    `WMH_ASSERT_NEXT(a_restart_after_close, aclk, aresetn, s_fire && req.fin,
        hash_reg == wmh_pkg::HashInit && len_reg == wmh_pkg::LenInit && m_tvalid)

    // state only moves on an accepted beat
    `WMH_ASSERT_NEXT(a_state_held_idle, aclk, aresetn, !s_fire,
        $stable(hash_reg) && $stable(len_reg))

    // an empty result register never back-pressures the input
    `WMH_ASSERT_NOW(a_ready_when_empty, aclk, aresetn, !m_tvalid, s_tready)

    // a beat that closes nothing raises no new result once the old one has gone
    `WMH_ASSERT_NEXT(a_no_spurious_result, aclk, aresetn,
        s_fire && !req.fin && (!m_tvalid || m_tready), !m_tvalid)

endmodule

// File: sim/word_mix_hash_stream_core_tb.sv
`timescale 1ns / 100ps
// testbench for word_mix_hash_stream_core: directed and random message beats, folded hashes
// checked against an in-bench hash predictor; depends on wmh_pkg and the core rtl only
module word_mix_hash_stream_core_tb;

    localparam int IdleLimit = 4000;   // cycles with no beat on either side before giving up
    localparam int DrainWait = 4;      // extra wait once every expected result is taken

    typedef enum int {
        RX_STEADY,
        RX_COIN,
        RX_MOSTLY_READY,
        RX_MOSTLY_STALLED
    } rx_mode_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata  = '0;   // [63:0] data_word, [67:64] byte_count, [71:68] zero
    logic        s_tlast  = 1'b0; // last
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;         // [31:0] hash_value

    // predictor state, mirrors the core's running hash and length byte
    logic [63:0] hash_state = wmh_pkg::HashInit;
    logic [7:0]  msg_len    = wmh_pkg::LenInit;
    logic [31:0] expected_hashes[$];

    int error_count  = 0;
    int words_sent   = 0;   // beats that carry bytes or close a message
    int burst_left   = 0;
    int hold_request = 0;   // long receiver hold-off asked for by a test
    int idle_cycles  = 0;

    word_mix_hash_stream_core uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 aclk = ~aclk;

    // absorb one accepted beat into the predicted hash, queue the fold when a message closes
    function automatic void absorb_word(input logic [63:0] word, input logic [3:0] cnt_in,
                                        input logic fin_in);
        int          cnt;
        logic        fin;
        logic [63:0] mask;
        logic [63:0] tail;
        cnt = (cnt_in > 4'd8) ? 8 : int'(cnt_in);
        fin = fin_in;
        if (cnt == 8) begin
            hash_state = (hash_state ^ word) * wmh_pkg::MixFull;
            msg_len    = msg_len + 8'd8;
        end else if (cnt != 0) begin
            // short word: length byte at the bottom, tail bytes above it, always closes
            mask       = (64'd1 << (cnt * 8)) - 64'd1;
            msg_len    = msg_len + 8'(cnt);
            tail       = ((word & mask) << 8) | {56'd0, msg_len};
            hash_state = (hash_state ^ tail) * wmh_pkg::MixTail;
            fin        = 1'b1;
        end
        if (fin) begin
            expected_hashes.push_back(hash_state[31:0] ^ hash_state[63:32]);
            hash_state = wmh_pkg::HashInit;
            msg_len    = wmh_pkg::LenInit;
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t mismatch %s: got %08h want %08h", $realtime, what, got, want);
        error_count++;
    endtask

    function automatic logic [63:0] rand_word();
        rand_word = {$urandom, $urandom};
    endfunction

    // byte count for a full word, now and then one of the saturating counts
    function automatic logic [3:0] full_count();
        full_count = ($urandom_range(0, 5) == 0) ? 4'($urandom_range(9, 15)) : 4'd8;
    endfunction

    // offer one beat, in bursts with random gaps, and hold it until taken
    task automatic send_word(input logic [63:0] word, input logic [3:0] cnt, input logic lst);
        int gap;
        if (burst_left == 0) begin
            case ($urandom_range(0, 7))
                0, 1, 2: gap = 0;
                7:       gap = $urandom_range(15, 30);
                default: gap = $urandom_range(1, 8);
            endcase
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 32);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0000, cnt, word};
        s_tlast  <= lst;
        do @(posedge aclk); while (!s_tready);
        absorb_word(word, cnt, lst);
        if (cnt != 4'd0 || lst) words_sent++;
        burst_left--;
    endtask

    // receiver: a long hold-off when asked, otherwise a stall pattern that changes now and then
    initial begin : receiver
        int       hold_left;
        int       mode_left;
        rx_mode_t rx_mode;
        hold_left = 0;
        mode_left = 0;
        rx_mode   = RX_STEADY;
        forever begin
            @(posedge aclk);
            if (hold_request > 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    rx_mode   = rx_mode_t'($urandom_range(0, 3));
                    mode_left = $urandom_range(8, 80);
                end
                mode_left--;
                case (rx_mode)
                    RX_STEADY:       m_tready <= 1'b1;
                    RX_COIN:         m_tready <= 1'($urandom_range(0, 1));
                    RX_MOSTLY_READY: m_tready <= ($urandom_range(0, 7) != 0);
                    default:         m_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // result checker and watchdog
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (expected_hashes.size() == 0) begin
                    report_mismatch("unexpected beat", m_tdata, 32'h0);
                end else begin
                    if (m_tdata !== expected_hashes[0])
                        report_mismatch("hash_value", m_tdata, expected_hashes[0]);
                    void'(expected_hashes.pop_front());
                end
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IdleLimit) begin
                $display("%0t watchdog: no beat for %0d cycles", $realtime, IdleLimit);
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    // extremes of the fields and each special case, one by one
    task automatic test_directed();
        int c;
        send_word(rand_word(), 4'd0, 1'b1);            // empty message, fold of the initial value
        send_word(64'h0, 4'd8, 1'b0);
        send_word('1, 4'd8, 1'b0);
        send_word(rand_word(), 4'd0, 1'b1);            // closes a two-word message
        for (c = 1; c <= 7; c++)                       // short words, junk above the count
            send_word(rand_word(), 4'(c), 1'(c % 2)); // with and without the last mark
        for (c = 9; c <= 15; c++)                      // counts that saturate to a full word
            send_word(rand_word(), 4'(c), 1'b0);
        send_word(rand_word(), 4'd0, 1'b1);
        send_word(rand_word(), 4'd0, 1'b0);            // empty word without last: no effect
        send_word('1, 4'd8, 1'b1);                     // full word carrying the last mark
    endtask

    // 264 bytes before the tail so the length byte wraps past 255
    task automatic test_length_wrap();
        int i;
        for (i = 0; i < 33; i++)
            send_word(rand_word(), 4'd8, 1'b0);
        send_word(rand_word(), 4'd5, 1'b0);
    endtask

    // receiver holds off while short words keep coming, so the result register fills
    // and the input has to stall
    task automatic test_backpressure();
        int i;
        hold_request = 300;
        for (i = 0; i < 40; i++)
            send_word(rand_word(), 4'($urandom_range(1, 7)), 1'($urandom_range(0, 1)));
    endtask

    // mostly well-formed messages with random content, some noise and odd endings
    task automatic test_random_messages(input int target);
        int          n_full;
        int          i;
        logic [63:0] w;
        while (words_sent < target) begin
            n_full = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 6);
            for (i = 0; i < n_full; i++) begin
                if ($urandom_range(0, 19) == 0)
                    send_word(rand_word(), 4'd0, 1'b0);
                case ($urandom_range(0, 15))
                    0:       w = '0;
                    1:       w = '1;
                    default: w = rand_word();
                endcase
                send_word(w, full_count(), 1'b0);
            end
            case ($urandom_range(0, 5))
                0, 1: send_word(rand_word(), 4'($urandom_range(1, 7)), 1'b1);
                2:    send_word(rand_word(), 4'($urandom_range(1, 7)), 1'b0);
                3:    send_word(rand_word(), 4'd0, 1'b1);
                4:    send_word(rand_word(), full_count(), 1'b1);
                default: begin
                    // noise: beats with any count and any last mark
                    for (i = $urandom_range(1, 4); i > 0; i--)
                        send_word(rand_word(), 4'($urandom_range(0, 15)),
                                  1'($urandom_range(0, 1)));
                end
            endcase
        end
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_length_wrap();
        test_backpressure();
        test_random_messages(1350);
        s_tvalid <= 1'b0;
        while (expected_hashes.size() != 0) @(posedge aclk);
        repeat (DrainWait) @(posedge aclk);
        if (error_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

// File: word_mix_hash_stream_core.f
+incdir+src
src/wmh_pkg.sv
src/wmh_front.sv
src/wmh_mix.sv
src/word_mix_hash_stream_core.sv
sim/word_mix_hash_stream_core_tb.sv
